@@ sv/nrsh_pkg.sv @@
// Shared types and constants for the nearest ray/segment hit block.
// Used by the wall store, the multiply-accumulate unit, the divider and the top level.
package nrsh_pkg;

  // Item kinds carried on s_tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  localparam int CFG_W  = 10;  // walls_in_use register
  localparam int SLOT_W = 9;

  // Datapath widths
  localparam int OPA_W  = 25;  // ax, ay and sign-extended direction terms
  localparam int OPB_W  = 17;  // bx, by and sign-extended direction terms
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int DEN_W  = 34;
  localparam int TN_W   = 43;
  localparam int SN_W   = 42;

  // Divider: numerator shift register, divisor, step counter
  localparam int DIV_NUM_W = 56;
  localparam int DIV_DEN_W = 33;
  localparam int STEP_W    = 6;
  localparam logic [STEP_W-1:0] T_DIV_STEPS = 6'd56;
  localparam logic [STEP_W-1:0] S_DIV_STEPS = 6'd8;

  typedef struct packed {
    logic [15:0] y2;
    logic [15:0] x2;
    logic [15:0] y1;
    logic [15:0] x1;
  } wall_t;

  typedef enum logic [1:0] {
    DST_DEN = 2'd0,
    DST_TN  = 2'd1,
    DST_SN  = 2'd2
  } mac_dst_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    mac_dst_t         dst;
    logic [OPA_W-1:0] a;
    logic [OPB_W-1:0] b;
  } mac_req_t;

  typedef struct packed {
    logic     valid;
    mac_dst_t dst;
  } mac_rsp_t;

  typedef struct packed {
    logic                 start;
    logic [STEP_W-1:0]    steps;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] rem0;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

@@ sv/nrsh_wall_mem.sv @@
// Wall segment store: one write port, one registered read port.
// Depends on nrsh_pkg for the wall entry layout.
module nrsh_wall_mem
  import nrsh_pkg::*;
#(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  wall_t         wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output wall_t         rd_data
);

  wall_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/nrsh_mac.sv @@
// Shared signed multiply-subtract unit: product register, then accumulator.
// A first step loads the product, the second subtracts it. Depends on nrsh_pkg.
module nrsh_mac
  import nrsh_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  mac_req_t                req,
  output mac_rsp_t                rsp,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [PROD_W-1:0] prod;
  logic                     p_valid;
  logic                     p_first;
  mac_dst_t                 p_dst;

  always_ff @(posedge clk) begin
    rsp.dst <= p_dst;
    if (rst) begin
      p_valid   <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      p_valid   <= req.valid;
      rsp.valid <= p_valid && !p_first;
    end
  end

  always_ff @(posedge clk) begin
    prod    <= $signed(req.a) * $signed(req.b);
    p_first <= req.first;
    p_dst   <= req.dst;
    if (p_valid) begin
      acc <= p_first ? ACC_W'(prod) : acc - ACC_W'(prod);
    end
  end

endmodule

@@ sv/nrsh_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by the t and s quotients.
// Starts from a preset remainder so short quotients need few steps. Depends on nrsh_pkg.
module nrsh_div
  import nrsh_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_NUM_W-1:0] numsh;
  logic [DIV_NUM_W-1:0] quo;
  logic [STEP_W-1:0]    cnt;
  logic                 busy;
  logic                 done;

  logic [DIV_DEN_W:0]   shifted;
  logic [DIV_DEN_W+1:0] diff;
  logic                 take;

  assign shifted = {rem, numsh[DIV_NUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_r};
  assign take    = !diff[DIV_DEN_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem   <= req.rem0;
      numsh <= req.num;
      den_r <= req.den;
      quo   <= '0;
    end else if (busy) begin
      rem   <= take ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
      numsh <= {numsh[DIV_NUM_W-2:0], 1'b0};
      quo   <= {quo[DIV_NUM_W-2:0], take};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

@@ sv/nearest_ray_segment_hit.sv @@
// Top level: wall store, scan sequencer, shared multiply unit and shared divider.
// Depends on nrsh_pkg, nrsh_wall_mem, nrsh_mac and nrsh_div.
//
// channel  dir  handshake             word contents
// s_*      in   s_tvalid / s_tready   wall write or ray cast (kind on s_tuser)
// m_*      out  m_tvalid / m_tready   nearest hit of one cast
// cfg_*    in   cfg_valid / cfg_ready walls_in_use
//
// A write word is accepted while idle. A cast scans each wall in turn, runs a t
// division for each wall the ray crosses, then finishes with an s division on a hit.
// The six products of a wall run one per cycle through the shared multiplier;
// t and s come one bit a cycle from the divider.
// Reset empties the pipeline and clears walls_in_use; the store itself is not cleared.
// s_tready is low while a cast runs; a finished result waits in the output register.
module nearest_ray_segment_hit
  import nrsh_pkg::*;
#(
  parameter int MAX_WALLS = 512
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [8:0] wall_slot, [24:9] seg_x1, [40:25] seg_y1, [56:41] seg_x2, [72:57] seg_y2,
  // [96:73] origin_x, [120:97] origin_y, [136:121] dir_x, [152:137] dir_y, zero pad
  input  logic [159:0] s_tdata,
  // [0] opcode
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [8:0] hit_wall, [32:9] hit_distance, [40:33] hit_along, zero pad
  output logic [47:0]  m_tdata,
  // [0] hit
  output logic         m_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [9:0]   cfg_data
);

  localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
  localparam int CW = $clog2(MAX_WALLS + 1);
  localparam int XW = (CW > CFG_W) ? CW : CFG_W;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_READ  = 11'b000_0000_0010,
    S_LOAD  = 11'b000_0000_0100,
    S_MUL   = 11'b000_0000_1000,
    S_MACW  = 11'b000_0001_0000,
    S_CHECK = 11'b000_0010_0000,
    S_DIVT  = 11'b000_0100_0000,
    S_NEXT  = 11'b000_1000_0000,
    S_FIN   = 11'b001_0000_0000,
    S_DIVS  = 11'b010_0000_0000,
    S_OUT   = 11'b100_0000_0000
  } state_t;

  // Product order for one wall
  localparam logic [2:0] MS_DEN_A = 3'd0;
  localparam logic [2:0] MS_DEN_B = 3'd1;
  localparam logic [2:0] MS_TN_A  = 3'd2;
  localparam logic [2:0] MS_TN_B  = 3'd3;
  localparam logic [2:0] MS_SN_A  = 3'd4;
  localparam logic [2:0] MS_SN_B  = 3'd5;

  state_t state, state_next;

  // Input word fields
  logic [SLOT_W-1:0]  in_slot;
  wall_t              in_wall;
  logic signed [23:0] in_ox, in_oy;
  logic signed [15:0] in_dx, in_dy;

  assign in_slot    = s_tdata[8:0];
  assign in_wall.x1 = s_tdata[24:9];
  assign in_wall.y1 = s_tdata[40:25];
  assign in_wall.x2 = s_tdata[56:41];
  assign in_wall.y2 = s_tdata[72:57];
  assign in_ox      = s_tdata[96:73];
  assign in_oy      = s_tdata[120:97];
  assign in_dx      = s_tdata[136:121];
  assign in_dy      = s_tdata[152:137];

  logic s_acc;
  assign s_tready  = (state == S_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  logic [CFG_W-1:0] walls_in_use;
  logic [XW-1:0]    max_x, slot_x, wiu_x, n_clamp;
  logic [XW-1:0]    scan_n, idx;

  assign max_x   = XW'(MAX_WALLS);
  assign slot_x  = XW'(in_slot);
  assign wiu_x   = XW'(walls_in_use);
  assign n_clamp = (wiu_x > max_x) ? max_x : wiu_x;

  // Wall store
  logic  wr_en;
  wall_t rd_wall;

  assign wr_en = s_acc && (s_tuser == OP_WRITE) && (slot_x < max_x);

  nrsh_wall_mem #(
    .DEPTH (MAX_WALLS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot_x[AW-1:0]),
    .wr_data (in_wall),
    .rd_en   (state == S_READ),
    .rd_addr (idx[AW-1:0]),
    .rd_data (rd_wall)
  );

  // Cast and wall operands
  logic signed [23:0]      ox, oy;
  logic signed [15:0]      dx, dy;
  logic signed [OPA_W-1:0] ax, ay;
  logic signed [OPB_W-1:0] bx, by;
  logic [2:0]              mstep;

  // Shared multiply unit
  mac_req_t                mac_req;
  mac_rsp_t                mac_rsp;
  logic signed [ACC_W-1:0] acc;

  always_comb begin
    mac_req.valid = (state == S_MUL);
    mac_req.first = !mstep[0];
    mac_req.dst   = DST_DEN;
    mac_req.a     = OPA_W'(dx);
    mac_req.b     = by;
    unique case (mstep)
      MS_DEN_A: begin
        mac_req.a = OPA_W'(dx);
        mac_req.b = by;
      end
      MS_DEN_B: begin
        mac_req.a = OPA_W'(dy);
        mac_req.b = bx;
      end
      MS_TN_A: begin
        mac_req.dst = DST_TN;
        mac_req.a   = ax;
        mac_req.b   = by;
      end
      MS_TN_B: begin
        mac_req.dst = DST_TN;
        mac_req.a   = ay;
        mac_req.b   = bx;
      end
      MS_SN_A: begin
        mac_req.dst = DST_SN;
        mac_req.a   = ax;
        mac_req.b   = OPB_W'(dy);
      end
      MS_SN_B: begin
        mac_req.dst = DST_SN;
        mac_req.a   = ay;
        mac_req.b   = OPB_W'(dx);
      end
      default: begin
        mac_req.valid = 1'b0;
      end
    endcase
  end

  nrsh_mac u_mac (
    .clk (clk),
    .rst (rst),
    .req (mac_req),
    .rsp (mac_rsp),
    .acc (acc)
  );

  logic signed [DEN_W-1:0] den;
  logic signed [TN_W-1:0]  tn;
  logic signed [SN_W-1:0]  sn;

  // Fold the sign of the denominator into t and s, then screen the wall
  logic                    den_neg;
  logic signed [DEN_W-1:0] den_abs;
  logic signed [TN_W-1:0]  tn_n;
  logic signed [SN_W-1:0]  sn_n;
  logic signed [SN_W-1:0]  s_lim;
  logic                    skip;

  assign den_neg = den[DEN_W-1];
  assign den_abs = den_neg ? -den : den;
  assign tn_n    = den_neg ? -tn : tn;
  assign sn_n    = den_neg ? -sn : sn;
  assign s_lim   = {1'b0, den_abs[DIV_DEN_W-1:0], 8'h00};
  assign skip    = (den == '0) || tn_n[TN_W-1] || (tn_n == '0) ||
                   sn_n[SN_W-1] || (sn_n > s_lim);

  logic                 found;
  logic [XW-1:0]        best_i;
  logic [DIV_NUM_W-1:0] best_t;
  logic [40:0]          cand_sn, best_sn;
  logic [DIV_DEN_W-1:0] cand_den, best_den;
  logic [7:0]           along;

  // s * 255 as a shift and subtract; floor(x / 256d) = floor(floor(x / 256) / d)
  logic [48:0] s_prod;
  assign s_prod = {best_sn, 8'h00} - {8'h00, best_sn};

  // Shared divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  always_comb begin
    div_req.start = ((state == S_CHECK) && !skip) || ((state == S_FIN) && found);
    if (state == S_FIN) begin
      div_req.steps = S_DIV_STEPS;
      div_req.num   = {s_prod[15:8], 48'h0};
      div_req.rem0  = s_prod[48:16];
      div_req.den   = best_den;
    end else begin
      div_req.steps = T_DIV_STEPS;
      div_req.num   = {tn_n[41:0], 14'h0};
      div_req.rem0  = '0;
      div_req.den   = den_abs[DIV_DEN_W-1:0];
    end
  end

  nrsh_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  logic better;
  assign better = !found || (div_rsp.quo < best_t);

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid && (s_tuser == OP_CAST)) begin
          state_next = (n_clamp == '0) ? S_FIN : S_READ;
        end
      end
      S_READ:  state_next = S_LOAD;
      S_LOAD:  state_next = S_MUL;
      S_MUL: begin
        if (mstep == MS_SN_B) begin
          state_next = S_MACW;
        end
      end
      S_MACW: begin
        if (mac_rsp.valid && (mac_rsp.dst == DST_SN)) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: state_next = skip ? S_NEXT : S_DIVT;
      S_DIVT: begin
        if (div_rsp.done) begin
          state_next = S_NEXT;
        end
      end
      S_NEXT:  state_next = ((idx + XW'(1)) == scan_n) ? S_FIN : S_READ;
      S_FIN:   state_next = found ? S_DIVS : S_OUT;
      S_DIVS: begin
        if (div_rsp.done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      walls_in_use <= '0;
      scan_n       <= '0;
      idx          <= '0;
      mstep        <= '0;
      found        <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        walls_in_use <= cfg_data;
      end
      if (s_acc && (s_tuser == OP_CAST)) begin
        scan_n <= n_clamp;
        idx    <= '0;
        found  <= 1'b0;
      end
      if (state == S_LOAD) begin
        mstep <= '0;
      end else if (state == S_MUL) begin
        mstep <= mstep + 3'd1;
      end
      if (state == S_NEXT) begin
        idx <= idx + XW'(1);
      end
      if ((state == S_DIVT) && div_rsp.done && better) begin
        found <= 1'b1;
      end
      if ((state == S_OUT) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc && (s_tuser == OP_CAST)) begin
      ox <= in_ox;
      oy <= in_oy;
      dx <= in_dx;
      dy <= in_dy;
    end
    if (state == S_LOAD) begin
      ax <= {rd_wall.x1[15], rd_wall.x1, 8'h00} - {ox[23], ox};
      ay <= {rd_wall.y1[15], rd_wall.y1, 8'h00} - {oy[23], oy};
      bx <= {rd_wall.x2[15], rd_wall.x2} - {rd_wall.x1[15], rd_wall.x1};
      by <= {rd_wall.y2[15], rd_wall.y2} - {rd_wall.y1[15], rd_wall.y1};
    end
    if (mac_rsp.valid) begin
      case (mac_rsp.dst)
        DST_DEN: den <= acc[DEN_W-1:0];
        DST_TN:  tn  <= acc[TN_W-1:0];
        DST_SN:  sn  <= acc[SN_W-1:0];
        default: den <= acc[DEN_W-1:0];
      endcase
    end
    if (state == S_CHECK) begin
      cand_sn  <= sn_n[40:0];
      cand_den <= den_abs[DIV_DEN_W-1:0];
    end
    // Strictly smaller t replaces, so ties keep the lower index
    if ((state == S_DIVT) && div_rsp.done && better) begin
      best_t   <= div_rsp.quo;
      best_i   <= idx;
      best_sn  <= cand_sn;
      best_den <= cand_den;
    end
    if ((state == S_DIVS) && div_rsp.done) begin
      along <= div_rsp.quo[7:0];
    end
    if ((state == S_OUT) && (!m_tvalid || m_tready)) begin
      m_tuser <= found;
      if (found) begin
        m_tdata <= {7'h00, along,
                    (|best_t[DIV_NUM_W-1:24]) ? 24'hFF_FFFF : best_t[23:0],
                    best_i[SLOT_W-1:0]};
      end else begin
        m_tdata <= '0;
      end
    end
  end

  // Checks
  a_word_from_out_state: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_OUT))
    else $error("result word raised outside the output state");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("miss word carries nonzero fields");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_best_in_scan: assert property (@(posedge clk) disable iff (rst)
    found |-> (best_i < scan_n))
    else $error("winning wall index beyond scan count");

endmodule
